/* src/assert_macros.svh */
// Assertion helpers for the frame parser checkers.
// Clock and reset names are taken from the scope that uses the macro.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define LPFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Checked at every edge, reset included.
`define LPFP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

/* src/lpfp_pkg.sv */
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants of the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

	localparam int TAG_BYTES   = 16;
	localparam int TAG_W       = $clog2(TAG_BYTES + 1);
	localparam int LEN_W       = 24;
	localparam int SID_W       = 64;
	localparam int HDR_W       = 4;
	localparam int CONS_W      = 25;
	localparam int LEN_BYTES   = 3;
	localparam int HDR_FIXED   = 4;
	localparam int VARINT_MAX  = 10;
	localparam int VARINT_BITS = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] STREAM_TYPE_RST  = 8'd0;
	localparam logic [7:0] WINUPD_TYPE_RST  = 8'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STREAM_TYPE = 1'b0,
		REG_WINUPD_TYPE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_HDR  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_TAG  = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_FRAME  = 2'd1,
		ERR_LENGTH = 2'd2
	} err_t;

	// compact record handed from the parser to the output stage
	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data;
		err_t              err;
		logic              eof;
		logic [LEN_W-1:0]  len;
		logic [7:0]        ftype;
		logic              has_id;
		logic [SID_W-1:0]  sid;
		logic [HDR_W-1:0]  hdr_cnt;
	} rec_t;

endpackage

/* src/length_prefixed_frame_parser.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Parses length-prefixed frames from a byte stream into records.
// ----------------------------------------------------------------------------
// Input channel: one wire byte per beat (data_byte, last_in_buffer), taken
// when in_valid is high and in_stall is low. Output channel: one record per
// beat, taken when out_valid is high and out_stall is low. Length bytes, the
// type byte before a stream id and non-final varint bytes give no record.
// Kinds: header (length, type, stream id), ciphertext byte, tag byte (the
// last one carries end_of_frame and bytes_consumed) and error.
// Throughput is one byte per cycle while in_stall is low. The edge that
// accepts a byte writes its record into a four-entry queue; the output
// register loads the record once it heads the queue and the register is
// empty or the receiver does not stall.
// While the receiver stalls, the output register holds its record and the
// queue fills; in_stall rises once the queue holds four records.
// Reset clears the parse state and the queue, drops any pending record and
// loads the type codes with 0 (stream) and 4 (window update).
// Configuration writes through cfg_we/cfg_index/cfg_data set the type codes.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser import lpfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  last_in_buffer,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            record_kind,
	output logic [LEN_W-1:0]      frame_length,
	output logic [7:0]            frame_type,
	output logic                  flow_id_present,
	output logic [SID_W-1:0]      flow_id,
	output logic [7:0]            payload_byte,
	output logic [1:0]            err_code,
	output logic                  end_of_frame,
	output logic [CONS_W-1:0]     bytes_consumed
);

	logic q_full, q_empty, push, pop;
	rec_t push_rec, q_head;

	assign in_stall = q_full;

	lpfp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_valid & ~q_full),
		.data_byte      (data_byte),
		.last_in_buffer (last_in_buffer),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.push_rec       (push_rec)
	);

	lpfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	lpfp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_head          (q_head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.record_kind     (record_kind),
		.frame_length    (frame_length),
		.frame_type      (frame_type),
		.flow_id_present (flow_id_present),
		.flow_id         (flow_id),
		.payload_byte    (payload_byte),
		.err_code        (err_code),
		.end_of_frame    (end_of_frame),
		.bytes_consumed  (bytes_consumed)
	);

endmodule

/* src/lpfp_front.sv */
// ----------------------------------------------------------------------------
// lpfp_front
// Byte parser: walks the frame phases and emits one record per result.
// ----------------------------------------------------------------------------
module lpfp_front import lpfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  last_in_buffer,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  push,
	output rec_t                  push_rec
);

	typedef enum logic [2:0] {
		PH_LEN     = 3'd0,
		PH_TYPE    = 3'd1,
		PH_VARINT  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_TAG     = 3'd4
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [1:0]         pfx_cnt_q, pfx_cnt_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [7:0]         type_q, type_d;
	logic [SID_W-1:0]   sid_q, sid_d;
	logic [3:0]         vcnt_q, vcnt_d;
	logic [LEN_W-1:0]   pay_rem_q, pay_rem_d;
	logic [TAG_W-1:0]   tag_rem_q, tag_rem_d;
	logic [HDR_W-1:0]   hdr_cnt_q, hdr_cnt_d;
	logic [7:0]         stream_type_q, winupd_type_q;

	logic               fin_hdr, fin_has, do_err, do_restart;
	err_t               err_sel;
	logic [5:0]         shamt;
	logic [TAG_W-1:0]   tag_dec;
	logic [1:0]         pfx_inc;
	logic [3:0]         vcnt_inc;

	assign shamt    = 6'(VARINT_BITS * vcnt_q);
	assign tag_dec  = (tag_rem_q != '0) ? tag_rem_q - 1'b1 : tag_rem_q;
	assign pfx_inc  = pfx_cnt_q + 1'b1;
	assign vcnt_inc = vcnt_q + 1'b1;

	always_comb begin
		phase_d    = phase_q;
		pfx_cnt_d  = pfx_cnt_q;
		len_d      = len_q;
		type_d     = type_q;
		sid_d      = sid_q;
		vcnt_d     = vcnt_q;
		pay_rem_d  = pay_rem_q;
		tag_rem_d  = tag_rem_q;
		hdr_cnt_d  = hdr_cnt_q;
		fin_hdr    = 1'b0;
		fin_has    = 1'b0;
		do_err     = 1'b0;
		do_restart = 1'b0;
		err_sel    = ERR_NONE;
		push       = 1'b0;
		push_rec   = '0;

		if (accept) begin
			unique case (phase_q)
				PH_LEN: begin
					len_d     = {len_q[LEN_W-9:0], data_byte};
					pfx_cnt_d = pfx_inc;
					if (last_in_buffer) begin
						do_err  = 1'b1;
						err_sel = ERR_FRAME;
					end else if (32'(pfx_inc) >= LEN_BYTES) begin
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					type_d    = data_byte;
					hdr_cnt_d = HDR_W'(HDR_FIXED);
					sid_d     = '0;
					if (data_byte != stream_type_q && data_byte != winupd_type_q) begin
						fin_hdr = 1'b1;
					end else if (last_in_buffer) begin
						do_err  = 1'b1;
						err_sel = ERR_FRAME;
					end else begin
						vcnt_d  = '0;
						phase_d = PH_VARINT;
					end
				end
				PH_VARINT: begin
					// bits that land past the top of the id are dropped
					sid_d     = sid_q | (SID_W'(data_byte[6:0]) << shamt);
					vcnt_d    = vcnt_inc;
					hdr_cnt_d = hdr_cnt_q + 1'b1;
					if (!data_byte[7]) begin
						fin_hdr = 1'b1;
						fin_has = 1'b1;
					end else if (32'(vcnt_inc) >= VARINT_MAX || last_in_buffer) begin
						do_err  = 1'b1;
						err_sel = ERR_FRAME;
					end
				end
				PH_PAYLOAD: begin
					if (last_in_buffer) begin
						do_err  = 1'b1;
						err_sel = ERR_LENGTH;
					end else begin
						push          = 1'b1;
						push_rec.kind = KIND_DATA;
						push_rec.data = data_byte;
						pay_rem_d     = pay_rem_q - 1'b1;
						if (pay_rem_d == '0) begin
							phase_d   = PH_TAG;
							tag_rem_d = TAG_W'(TAG_BYTES);
						end
					end
				end
				PH_TAG: begin
					tag_rem_d = tag_dec;
					if (tag_dec == '0) begin
						push             = 1'b1;
						push_rec.kind    = KIND_TAG;
						push_rec.data    = data_byte;
						push_rec.eof     = 1'b1;
						push_rec.len     = len_q;
						push_rec.hdr_cnt = hdr_cnt_q;
						do_restart       = 1'b1;
					end else if (last_in_buffer) begin
						do_err  = 1'b1;
						err_sel = ERR_LENGTH;
					end else begin
						push          = 1'b1;
						push_rec.kind = KIND_TAG;
						push_rec.data = data_byte;
					end
				end
				default: do_restart = 1'b1;
			endcase

			if (fin_hdr) begin
				if (last_in_buffer) begin
					do_err  = 1'b1;
					err_sel = ERR_LENGTH;
				end else begin
					push            = 1'b1;
					push_rec.kind   = KIND_HDR;
					push_rec.len    = len_d;
					push_rec.ftype  = type_d;
					push_rec.has_id = fin_has;
					push_rec.sid    = fin_has ? sid_d : '0;
					if (len_d == '0) begin
						phase_d   = PH_TAG;
						tag_rem_d = TAG_W'(TAG_BYTES);
					end else begin
						phase_d   = PH_PAYLOAD;
						pay_rem_d = len_d;
					end
				end
			end

			if (do_err) begin
				push          = 1'b1;
				push_rec      = '0;
				push_rec.kind = KIND_ERR;
				push_rec.err  = err_sel;
				do_restart    = 1'b1;
			end

			if (do_restart) begin
				phase_d   = PH_LEN;
				pfx_cnt_d = '0;
				len_d     = '0;
				type_d    = '0;
				sid_d     = '0;
				vcnt_d    = '0;
				pay_rem_d = '0;
				tag_rem_d = '0;
				hdr_cnt_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN;
			pfx_cnt_q <= '0;
			len_q     <= '0;
			type_q    <= '0;
			sid_q     <= '0;
			vcnt_q    <= '0;
			pay_rem_q <= '0;
			tag_rem_q <= '0;
			hdr_cnt_q <= '0;
		end else begin
			phase_q   <= phase_d;
			pfx_cnt_q <= pfx_cnt_d;
			len_q     <= len_d;
			type_q    <= type_d;
			sid_q     <= sid_d;
			vcnt_q    <= vcnt_d;
			pay_rem_q <= pay_rem_d;
			tag_rem_q <= tag_rem_d;
			hdr_cnt_q <= hdr_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_type_q <= STREAM_TYPE_RST;
			winupd_type_q <= WINUPD_TYPE_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STREAM_TYPE: stream_type_q <= cfg_data;
				REG_WINUPD_TYPE: winupd_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* src/lpfp_queue.sv */
// ----------------------------------------------------------------------------
// lpfp_queue
// Short record queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module lpfp_queue import lpfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	input  logic pop,
	output logic full,
	output logic empty,
	output rec_t head
);

	rec_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/lpfp_back.sv */
// ----------------------------------------------------------------------------
// lpfp_back
// Output stage: expands queued records into result fields and holds them.
// ----------------------------------------------------------------------------
module lpfp_back import lpfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  rec_t                q_head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          record_kind,
	output logic [LEN_W-1:0]    frame_length,
	output logic [7:0]          frame_type,
	output logic                flow_id_present,
	output logic [SID_W-1:0]    flow_id,
	output logic [7:0]          payload_byte,
	output logic [1:0]          err_code,
	output logic                end_of_frame,
	output logic [CONS_W-1:0]   bytes_consumed
);

	logic               valid_q;
	logic [1:0]         kind_q, err_q;
	logic [LEN_W-1:0]   len_q;
	logic [7:0]         type_q, byte_q;
	logic               has_q, eof_q;
	logic [SID_W-1:0]   sid_q;
	logic [CONS_W-1:0]  cons_q;
	logic               is_hdr, is_pass;

	assign pop     = !q_empty && (!valid_q || !out_stall);
	assign is_hdr  = (q_head.kind == KIND_HDR);
	assign is_pass = (q_head.kind == KIND_DATA) || (q_head.kind == KIND_TAG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= q_head.kind;
			len_q  <= is_hdr ? q_head.len : '0;
			type_q <= is_hdr ? q_head.ftype : '0;
			has_q  <= is_hdr & q_head.has_id;
			sid_q  <= is_hdr ? q_head.sid : '0;
			byte_q <= is_pass ? q_head.data : '0;
			err_q  <= q_head.err;
			eof_q  <= q_head.eof;
			// total frame size: header + ciphertext + tag
			cons_q <= q_head.eof
				? CONS_W'(q_head.hdr_cnt) + CONS_W'(q_head.len) + CONS_W'(TAG_BYTES)
				: '0;
		end
	end

	assign out_valid       = valid_q;
	assign record_kind     = kind_q;
	assign frame_length    = len_q;
	assign frame_type      = type_q;
	assign flow_id_present = has_q;
	assign flow_id         = sid_q;
	assign payload_byte    = byte_q;
	assign err_code        = err_q;
	assign end_of_frame    = eof_q;
	assign bytes_consumed  = cons_q;

endmodule

/* src/lpfp_chk.sv */
// ----------------------------------------------------------------------------
// lpfp_chk
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpfp_chk import lpfp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [1:0]            record_kind,
	input logic [1:0]            err_code,
	input logic                  end_of_frame,
	input logic [CONS_W-1:0]     bytes_consumed
);

	`LPFP_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(record_kind), "record dropped under stall")
	`LPFP_ASSERT(a_eof_tag, out_valid && end_of_frame |-> record_kind == KIND_TAG, "end of frame on a non-tag record")
	`LPFP_ASSERT(a_err_code, out_valid && record_kind != KIND_ERR |-> err_code == ERR_NONE, "error code outside an error record")
	`LPFP_ASSERT(a_cons_eof, out_valid && !end_of_frame |-> bytes_consumed == '0, "byte count outside end of frame")
	`LPFP_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind length_prefixed_frame_parser lpfp_chk u_lpfp_chk (.*);
